FILE: rtl/core/eipc_pkg.sv
// Shared constants, types and the sequencer microcode for the index/pot calibrator.
`timescale 1ns / 1ps

package eipc_pkg;

  // Field and state widths
  localparam int IN_W   = 32;               // encoder and pot sample width
  localparam int POS_W  = 32;               // result position width
  localparam int CNT_W  = 24;               // sample counter width
  localparam int CFG_W  = 24;               // configuration data width
  localparam int CFG_IDX_W = 1;
  localparam int DIFF_W = IN_W + 1;         // pot minus encoder
  localparam int SUM_W  = DIFF_W + CNT_W + 1;
  localparam int Q_W    = IN_W + 2;         // floor(sum / n)
  localparam int A_W    = Q_W + 3;          // 2*(idx + q) - u
  localparam int DVS_W  = CFG_W + 1;        // divisor, up to 2u
  localparam int P_W    = DVS_W + CNT_W;    // multiplier product
  localparam int V_W    = P_W + 1;          // m*n + 2r, and 2*n*u
  localparam int OFF_W  = 40;               // stored offset
  localparam int PSUM_W = OFF_W + 1;        // encoder plus offset
  localparam int DIV_N  = SUM_W;            // divider iterations
  localparam int DIV_CNT_W = $clog2(DIV_N + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] CPI_RESET  = CFG_W'(4096);
  localparam logic [CFG_W-1:0] MINS_RESET = CFG_W'(50);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_INDEX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES      = 1'b1;

  // Input function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // Divider handshake
  typedef struct packed {
    logic load;
    logic run;
  } div_ctl_t;

  typedef struct packed {
    logic last;   // the current iteration is the final one
    logic idle;
  } div_sts_t;

  // Microcode
  localparam int STEP_W = 4;

  typedef enum logic [3:0] {
    OP_NOP, OP_LATCH, OP_UPDATE, OP_DIV_SUM, OP_DIV_RUN, OP_FIX_Q, OP_CALC_A,
    OP_DIV_A, OP_FIX_M, OP_MUL_MN, OP_MUL_NU, OP_CMP, OP_APPLY, OP_WRITE
  } op_t;

  typedef enum logic [1:0] {
    HOLD_NONE, HOLD_IN, HOLD_DIV, HOLD_OUT
  } hold_t;

  typedef enum logic [1:0] {
    JMP_NONE, JMP_ALWAYS, JMP_FUNC, JMP_NO_CAL
  } jmp_t;

  typedef struct packed {
    op_t               op;
    hold_t             hold_c;
    jmp_t              jmp_c;
    logic [STEP_W-1:0] target;
  } ucw_t;

  localparam logic [STEP_W-1:0] STEP_WAIT  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_UPD   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_TEST  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LD1   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_RUN1  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_FIX1  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_CALC  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_LD2   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RUN2  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FIX2  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_MUL1  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_MUL2  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_CMP   = 4'd12;
  localparam logic [STEP_W-1:0] STEP_APPLY = 4'd13;
  localparam logic [STEP_W-1:0] STEP_OUT   = 4'd14;

  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    unique case (step)
      STEP_WAIT:  w = '{op: OP_LATCH,  hold_c: HOLD_IN,   jmp_c: JMP_NONE,   target: STEP_WAIT};
      STEP_UPD:   w = '{op: OP_UPDATE, hold_c: HOLD_NONE, jmp_c: JMP_FUNC,   target: STEP_OUT};
      STEP_TEST:  w = '{op: OP_NOP,    hold_c: HOLD_NONE, jmp_c: JMP_NO_CAL, target: STEP_OUT};
      STEP_LD1:   w = '{op: OP_DIV_SUM, hold_c: HOLD_NONE, jmp_c: JMP_NONE,  target: STEP_WAIT};
      STEP_RUN1:  w = '{op: OP_DIV_RUN, hold_c: HOLD_DIV, jmp_c: JMP_NONE,   target: STEP_WAIT};
      STEP_FIX1:  w = '{op: OP_FIX_Q,  hold_c: HOLD_NONE, jmp_c: JMP_NONE,   target: STEP_WAIT};
      STEP_CALC:  w = '{op: OP_CALC_A, hold_c: HOLD_NONE, jmp_c: JMP_NONE,   target: STEP_WAIT};
      STEP_LD2:   w = '{op: OP_DIV_A,  hold_c: HOLD_NONE, jmp_c: JMP_NONE,   target: STEP_WAIT};
      STEP_RUN2:  w = '{op: OP_DIV_RUN, hold_c: HOLD_DIV, jmp_c: JMP_NONE,   target: STEP_WAIT};
      STEP_FIX2:  w = '{op: OP_FIX_M,  hold_c: HOLD_NONE, jmp_c: JMP_NONE,   target: STEP_WAIT};
      STEP_MUL1:  w = '{op: OP_MUL_MN, hold_c: HOLD_NONE, jmp_c: JMP_NONE,   target: STEP_WAIT};
      STEP_MUL2:  w = '{op: OP_MUL_NU, hold_c: HOLD_NONE, jmp_c: JMP_NONE,   target: STEP_WAIT};
      STEP_CMP:   w = '{op: OP_CMP,    hold_c: HOLD_NONE, jmp_c: JMP_NONE,   target: STEP_WAIT};
      STEP_APPLY: w = '{op: OP_APPLY,  hold_c: HOLD_NONE, jmp_c: JMP_NONE,   target: STEP_WAIT};
      STEP_OUT:   w = '{op: OP_WRITE,  hold_c: HOLD_OUT,  jmp_c: JMP_ALWAYS, target: STEP_WAIT};
      default:    w = '{op: OP_NOP,    hold_c: HOLD_NONE, jmp_c: JMP_ALWAYS, target: STEP_WAIT};
    endcase
    return w;
  endfunction

  // Clamp a wide signed position to the signed POS_W range
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [PSUM_W-1:0] p);
    logic signed [PSUM_W-1:0] hi;
    logic signed [PSUM_W-1:0] lo;
    hi = PSUM_W'({1'b0, {(POS_W-1){1'b1}}});
    lo = ~hi;
    if (p > hi) begin
      return hi[POS_W-1:0];
    end else if (p < lo) begin
      return lo[POS_W-1:0];
    end
    return p[POS_W-1:0];
  endfunction

endpackage

FILE: rtl/core/eipc_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
`timescale 1ns / 1ps

interface eipc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic signed [eipc_pkg::IN_W-1:0] encoder_count;
  logic signed [eipc_pkg::IN_W-1:0] pot_reading;
  logic                            index_seen;

  modport source (output valid, func, encoder_count, pot_reading, index_seen,
                  input ready);
  modport sink   (input valid, func, encoder_count, pot_reading, index_seen,
                  output ready);
endinterface

interface eipc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [eipc_pkg::POS_W-1:0] position;
  logic                             offset_valid;
  logic                             offset_mismatch;

  modport source (output valid, position, offset_valid, offset_mismatch,
                  input ready);
  modport sink   (input valid, position, offset_valid, offset_mismatch,
                  output ready);
endinterface

interface eipc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [eipc_pkg::CFG_IDX_W-1:0]     index;
  logic [eipc_pkg::CFG_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/eipc_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle while run is held.
`timescale 1ns / 1ps

module eipc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  eipc_pkg::div_ctl_t               ctl,
  input  logic [eipc_pkg::DIV_N-1:0]       dividend,
  input  logic [eipc_pkg::DVS_W-1:0]       divisor,
  output logic [eipc_pkg::DIV_N-1:0]       quotient,
  output logic [eipc_pkg::DVS_W-1:0]       remainder,
  output eipc_pkg::div_sts_t               sts
);

  logic [eipc_pkg::DIV_N-1:0]     quo_r, quo_nxt;
  logic [eipc_pkg::DVS_W:0]       rem_r, rem_nxt;
  logic [eipc_pkg::DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [eipc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [eipc_pkg::DVS_W:0]       trial;

  // shift next dividend bit into the partial remainder
  assign trial = {rem_r[eipc_pkg::DVS_W-1:0], quo_r[eipc_pkg::DIV_N-1]};

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = eipc_pkg::DIV_CNT_W'(eipc_pkg::DIV_N);
    end else if (ctl.run && (cnt_r != '0)) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[eipc_pkg::DIV_N-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[eipc_pkg::DIV_N-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r[eipc_pkg::DVS_W-1:0];
  assign sts.last  = (cnt_r == eipc_pkg::DIV_CNT_W'(1));
  assign sts.idle  = (cnt_r == '0);

endmodule

FILE: rtl/core/encoder_index_pot_calibrator.sv
// Top level of the encoder index / potentiometer calibrator.
`timescale 1ns / 1ps

// Takes one request at a time. Each sample adds pot minus encoder to a running
// sum (frozen once the 24-bit sample count saturates) and latches the encoder
// count on an index pulse. A plain sample passes the latch, update, test and
// result steps, and a clear request skips the test step. When a pulse is
// pending and at least min_samples samples are in, the section
// ceil((2n*idx + 2*sum - n*U) / (2*n*U)) is worked out exactly: a floor divide
// of the sum by n, then a floor divide by 2U, each on one shared bit-serial
// divider of 58 iterations, plus a few steps around them. The first result
// sets the offset and the calibrated flag, later disagreeing ones set the
// sticky mismatch flag. Control is a 15-step microprogram; the result sits in
// an output register, so the next request is taken while it waits. Register
// writes are taken at any time and must only be issued while the block is
// idle.
module encoder_index_pot_calibrator (
  input  logic              clk,
  input  logic              rst_n,
  eipc_in_if.sink           in_port,
  eipc_out_if.source        out_port,
  eipc_cfg_if.sink          cfg_port
);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic [eipc_pkg::STEP_W-1:0] pc_r, pc_nxt;
  eipc_pkg::ucw_t              ucw;
  logic                        hold;
  logic                        take_jmp;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  logic [eipc_pkg::CFG_W-1:0]  cpi_r, cpi_nxt;      // counts per index
  logic [eipc_pkg::CFG_W-1:0]  mins_r, mins_nxt;    // min samples

  logic                        func_r, func_nxt;
  logic [eipc_pkg::IN_W-1:0]   enc_r, enc_nxt;
  logic [eipc_pkg::IN_W-1:0]   pot_r, pot_nxt;
  logic                        idx_r, idx_nxt;

  logic [eipc_pkg::SUM_W-1:0]  sum_r, sum_nxt;      // signed running sum
  logic [eipc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        pend_r, pend_nxt;
  logic [eipc_pkg::IN_W-1:0]   ppos_r, ppos_nxt;    // latched index position
  logic [eipc_pkg::OFF_W-1:0]  off_r, off_nxt;      // signed offset
  logic                        cal_r, cal_nxt;
  logic                        mis_r, mis_nxt;

  // section arithmetic scratch
  logic                        neg_r, neg_nxt;      // dividend sign
  logic [eipc_pkg::Q_W-1:0]    q_r, q_nxt;
  logic [eipc_pkg::CNT_W-1:0]  r_r, r_nxt;
  logic [eipc_pkg::A_W-1:0]    a_r, a_nxt;
  logic [eipc_pkg::DVS_W-1:0]  m_r, m_nxt;
  logic [eipc_pkg::P_W-1:0]    p_r, p_nxt;
  logic [eipc_pkg::V_W-1:0]    v_r, v_nxt;
  logic [1:0]                  c_r, c_nxt;          // ceiling term, 0..2

  logic                        out_valid_r, out_valid_nxt;
  logic [eipc_pkg::POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic                        out_cal_r, out_cal_nxt;
  logic                        out_mis_r, out_mis_nxt;

  // ---------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------
  logic [eipc_pkg::CFG_W-1:0]  u;                   // zero period reads as one
  logic [eipc_pkg::DVS_W-1:0]  u2;
  logic                        cal_ready;
  logic                        out_free;

  logic [eipc_pkg::DIFF_W-1:0] diff;
  logic [eipc_pkg::SUM_W-1:0]  sum_abs;
  logic [eipc_pkg::A_W-1:0]    a_abs;
  logic [eipc_pkg::A_W-1:0]    idx_q;

  logic [eipc_pkg::DVS_W-1:0]  mul_a;
  logic [eipc_pkg::P_W-1:0]    mul_p;
  logic [eipc_pkg::V_W-1:0]    d_full;

  logic signed [eipc_pkg::OFF_W-1:0]  am_diff;
  logic signed [eipc_pkg::OFF_W-1:0]  am_half;
  logic [eipc_pkg::OFF_W-1:0]         cu;
  logic [eipc_pkg::OFF_W-1:0]         off_new;
  logic signed [eipc_pkg::PSUM_W-1:0] pos_sum;

  eipc_pkg::div_ctl_t          div_ctl;
  eipc_pkg::div_sts_t          div_sts;
  logic [eipc_pkg::DIV_N-1:0]  div_dividend;
  logic [eipc_pkg::DVS_W-1:0]  div_divisor;
  logic [eipc_pkg::DIV_N-1:0]  div_quo;
  logic [eipc_pkg::DVS_W-1:0]  div_rem;

  assign ucw = eipc_pkg::ucode(pc_r);

  assign u  = (cpi_r == '0) ? eipc_pkg::CFG_W'(1) : cpi_r;
  assign u2 = {u, 1'b0};

  // calibration may run: pulse waiting and enough samples
  assign cal_ready = pend_r && (cnt_r >= mins_r) && (cnt_r != '0);
  assign out_free  = !out_valid_r || out_port.ready;

  always_comb begin
    unique case (ucw.hold_c)
      eipc_pkg::HOLD_NONE: hold = 1'b0;
      eipc_pkg::HOLD_IN:   hold = !in_port.valid;
      eipc_pkg::HOLD_DIV:  hold = !div_sts.last;
      eipc_pkg::HOLD_OUT:  hold = !out_free;
      default:             hold = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ucw.jmp_c)
      eipc_pkg::JMP_NONE:   take_jmp = 1'b0;
      eipc_pkg::JMP_ALWAYS: take_jmp = 1'b1;
      eipc_pkg::JMP_FUNC:   take_jmp = (func_r == eipc_pkg::FUNC_CLEAR);
      eipc_pkg::JMP_NO_CAL: take_jmp = !cal_ready;
      default:              take_jmp = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (take_jmp) begin
      pc_nxt = ucw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  // pot minus encoder, 33-bit signed
  assign diff = {pot_r[eipc_pkg::IN_W-1], pot_r} - {enc_r[eipc_pkg::IN_W-1], enc_r};

  assign sum_abs = sum_r[eipc_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign a_abs   = a_r[eipc_pkg::A_W-1] ? (~a_r + 1'b1) : a_r;

  // idx + q, sign extended
  assign idx_q = {{(eipc_pkg::A_W-eipc_pkg::IN_W){ppos_r[eipc_pkg::IN_W-1]}}, ppos_r}
               + {{(eipc_pkg::A_W-eipc_pkg::Q_W){q_r[eipc_pkg::Q_W-1]}}, q_r};

  // one shared multiplier: m*n, then n*u
  assign mul_a = (ucw.op == eipc_pkg::OP_MUL_MN) ? m_r : {1'b0, u};
  assign mul_p = {{eipc_pkg::CNT_W{1'b0}}, mul_a}
               * {{eipc_pkg::DVS_W{1'b0}}, cnt_r};

  assign d_full = {p_r, 1'b0};                      // 2*n*u

  // offset = (a - m)/2 + c*u - idx, the halving is exact
  assign am_diff = $signed({{(eipc_pkg::OFF_W-eipc_pkg::A_W){a_r[eipc_pkg::A_W-1]}}, a_r})
                 - $signed({{(eipc_pkg::OFF_W-eipc_pkg::DVS_W){1'b0}}, m_r});
  assign am_half = am_diff >>> 1;
  assign cu = (c_r == 2'd2) ? {{(eipc_pkg::OFF_W-eipc_pkg::DVS_W){1'b0}}, u2} :
              (c_r == 2'd1) ? {{(eipc_pkg::OFF_W-eipc_pkg::CFG_W){1'b0}}, u} :
                              '0;
  assign off_new = am_half + cu
                 - {{(eipc_pkg::OFF_W-eipc_pkg::IN_W){ppos_r[eipc_pkg::IN_W-1]}}, ppos_r};

  assign pos_sum = $signed({{(eipc_pkg::PSUM_W-eipc_pkg::IN_W){enc_r[eipc_pkg::IN_W-1]}}, enc_r})
                 + $signed({off_r[eipc_pkg::OFF_W-1], off_r});

  // ---------------------------------------------------------------------
  // Divider: sum / n first, then a / 2u
  // ---------------------------------------------------------------------
  assign div_ctl.load = (ucw.op == eipc_pkg::OP_DIV_SUM) || (ucw.op == eipc_pkg::OP_DIV_A);
  assign div_ctl.run  = (ucw.op == eipc_pkg::OP_DIV_RUN);
  assign div_dividend = (ucw.op == eipc_pkg::OP_DIV_SUM) ? sum_abs
                      : {{(eipc_pkg::DIV_N-eipc_pkg::A_W){1'b0}}, a_abs};
  assign div_divisor  = (ucw.op == eipc_pkg::OP_DIV_SUM) ? {1'b0, cnt_r} : u2;

  eipc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .sts       (div_sts)
  );

  // ---------------------------------------------------------------------
  // Datapath micro-operations
  // ---------------------------------------------------------------------
  always_comb begin
    cpi_nxt  = cpi_r;
    mins_nxt = mins_r;
    func_nxt = func_r;
    enc_nxt  = enc_r;
    pot_nxt  = pot_r;
    idx_nxt  = idx_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    ppos_nxt = ppos_r;
    off_nxt  = off_r;
    cal_nxt  = cal_r;
    mis_nxt  = mis_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    a_nxt    = a_r;
    m_nxt    = m_r;
    p_nxt    = p_r;
    v_nxt    = v_r;
    c_nxt    = c_r;
    out_pos_nxt = out_pos_r;
    out_cal_nxt = out_cal_r;
    out_mis_nxt = out_mis_r;
    out_valid_nxt = out_valid_r && !out_port.ready;

    // register writes
    if (cfg_port.valid) begin
      case (cfg_port.index)
        eipc_pkg::CFG_COUNTS_PER_INDEX: cpi_nxt  = cfg_port.data;
        eipc_pkg::CFG_MIN_SAMPLES:      mins_nxt = cfg_port.data;
        default: ;
      endcase
    end

    unique case (ucw.op)
      eipc_pkg::OP_LATCH: begin
        if (in_port.valid) begin
          func_nxt = in_port.func;
          enc_nxt  = in_port.encoder_count;
          pot_nxt  = in_port.pot_reading;
          idx_nxt  = in_port.index_seen;
        end
      end
      eipc_pkg::OP_UPDATE: begin
        if (func_r == eipc_pkg::FUNC_CLEAR) begin
          sum_nxt  = '0;
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
          off_nxt  = '0;
          cal_nxt  = 1'b0;
          mis_nxt  = 1'b0;
        end else begin
          // accumulation freezes once the count saturates
          if (cnt_r != eipc_pkg::CNT_MAX) begin
            sum_nxt = sum_r + {{(eipc_pkg::SUM_W-eipc_pkg::DIFF_W){diff[eipc_pkg::DIFF_W-1]}},
                               diff};
            cnt_nxt = cnt_r + 1'b1;
          end
          if (idx_r) begin
            pend_nxt = 1'b1;
            ppos_nxt = enc_r;
          end
        end
      end
      eipc_pkg::OP_DIV_SUM: neg_nxt = sum_r[eipc_pkg::SUM_W-1];
      eipc_pkg::OP_FIX_Q: begin
        // floor correction for a negative sum
        if (!neg_r) begin
          q_nxt = div_quo[eipc_pkg::Q_W-1:0];
          r_nxt = div_rem[eipc_pkg::CNT_W-1:0];
        end else if (div_rem != '0) begin
          q_nxt = ~div_quo[eipc_pkg::Q_W-1:0];
          r_nxt = cnt_r - div_rem[eipc_pkg::CNT_W-1:0];
        end else begin
          q_nxt = ~div_quo[eipc_pkg::Q_W-1:0] + 1'b1;
          r_nxt = '0;
        end
      end
      eipc_pkg::OP_CALC_A: begin
        a_nxt = {idx_q[eipc_pkg::A_W-2:0], 1'b0}
              - {{(eipc_pkg::A_W-eipc_pkg::CFG_W){1'b0}}, u};
      end
      eipc_pkg::OP_DIV_A: neg_nxt = a_r[eipc_pkg::A_W-1];
      eipc_pkg::OP_FIX_M: begin
        if (!neg_r) begin
          m_nxt = div_rem;
        end else if (div_rem != '0) begin
          m_nxt = u2 - div_rem;
        end else begin
          m_nxt = '0;
        end
      end
      eipc_pkg::OP_MUL_MN: p_nxt = mul_p;
      eipc_pkg::OP_MUL_NU: begin
        v_nxt = {1'b0, p_r} + {{(eipc_pkg::V_W-eipc_pkg::CNT_W-1){1'b0}}, r_r, 1'b0};
        p_nxt = mul_p;
      end
      eipc_pkg::OP_CMP: begin
        // v < 2d, so the ceiling is 0, 1 or 2
        if (v_r == '0) begin
          c_nxt = 2'd0;
        end else if (v_r <= d_full) begin
          c_nxt = 2'd1;
        end else begin
          c_nxt = 2'd2;
        end
      end
      eipc_pkg::OP_APPLY: begin
        if (!cal_r) begin
          off_nxt = off_new;
          cal_nxt = 1'b1;
        end else if (off_r != off_new) begin
          mis_nxt = 1'b1;
        end
        pend_nxt = 1'b0;
      end
      eipc_pkg::OP_WRITE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = eipc_pkg::sat_pos(pos_sum);
          out_cal_nxt   = cal_r;
          out_mis_nxt   = mis_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= eipc_pkg::STEP_WAIT;
      cpi_r       <= eipc_pkg::CPI_RESET;
      mins_r      <= eipc_pkg::MINS_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      off_r       <= '0;
      cal_r       <= 1'b0;
      mis_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      cpi_r       <= cpi_nxt;
      mins_r      <= mins_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      off_r       <= off_nxt;
      cal_r       <= cal_nxt;
      mis_r       <= mis_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r    <= func_nxt;
    enc_r     <= enc_nxt;
    pot_r     <= pot_nxt;
    idx_r     <= idx_nxt;
    ppos_r    <= ppos_nxt;
    neg_r     <= neg_nxt;
    q_r       <= q_nxt;
    r_r       <= r_nxt;
    a_r       <= a_nxt;
    m_r       <= m_nxt;
    p_r       <= p_nxt;
    v_r       <= v_nxt;
    c_r       <= c_nxt;
    out_pos_r <= out_pos_nxt;
    out_cal_r <= out_cal_nxt;
    out_mis_r <= out_mis_nxt;
  end

  // ---------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------
  assign in_port.ready = (pc_r == eipc_pkg::STEP_WAIT);
  assign cfg_port.ready = 1'b1;

  assign out_port.valid           = out_valid_r;
  assign out_port.position        = out_pos_r;
  assign out_port.offset_valid    = out_cal_r;
  assign out_port.offset_mismatch = out_mis_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a mismatch can only follow a calibration
  a_mis_needs_cal: assert property (@(posedge clk) disable iff (!rst_n)
    mis_r |-> cal_r)
    else $error("mismatch flag set while not calibrated");

  // quotient/remainder are only consumed after the divider has finished
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == eipc_pkg::STEP_FIX1 || pc_r == eipc_pkg::STEP_FIX2) |-> div_sts.idle)
    else $error("divider result used before completion");

  // every calibration event consumes the pending pulse
  a_pulse_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == eipc_pkg::STEP_APPLY) |=> !pend_r)
    else $error("pending index pulse survived calibration");

  // leaving the result step always produces a result
  a_result_written: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == eipc_pkg::STEP_OUT && out_free) |=> out_valid_r)
    else $error("result step completed without a result");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the encoder index / pot calibrator.
`timescale 1ns / 1ps

// Feeds sample and clear requests through the valid/ready input channel and
// checks every result against a cycle-free model of the calibration math.
// Most random traffic is built as calibration runs: a clear, then samples
// whose pot reading tracks the encoder plus a fixed offset with a little
// noise, with index pulses landing on whole index periods. Those runs agree
// on one offset, so the calibrated path and the agreeing-index path get real
// coverage. Misaligned pulses and bursts of fully random requests drive the
// mismatch flag and position saturation. Register settings change only
// between phases, once every result is back.
module testbench;
  import eipc_pkg::*;

  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     SETTLE_CYCLES = 10;      // idle gap before a register write
  localparam int     DRAIN_CYCLES = 150;      // covers one full calibration request
  localparam longint S32_MAX = (longint'(1) << 31) - 1;
  localparam longint S32_MIN = -(longint'(1) << 31);
  localparam longint POS_HI = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_LO = -POS_HI - 1;

  typedef struct packed {
    logic            func;
    logic [IN_W-1:0] encoder_count;
    logic [IN_W-1:0] pot_reading;
    logic            index_seen;
  } sample_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             offset_valid;
    logic             offset_mismatch;
  } cal_result_t;

  logic clk;
  logic rst_n;

  eipc_in_if  in_ch ();
  eipc_out_if out_ch ();
  eipc_cfg_if cfg_ch ();

  encoder_index_pot_calibrator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_ch),
    .out_port (out_ch),
    .cfg_port (cfg_ch)
  );

  sample_t     sample_fifo[$];     // requests waiting for the driver
  cal_result_t expected_q[$];      // predicted results, oldest first
  int          errors;
  int          cycle_cnt;
  int          send_gap_pct;
  int          recv_stall_pct;

  // Settings as last written, for shaping stimulus
  logic [CFG_W-1:0] gen_cpi;
  logic [CFG_W-1:0] gen_mins;

  // Model state
  logic [CFG_W-1:0] m_cpi;
  logic [CFG_W-1:0] m_mins;
  longint           diff_total;
  logic [CNT_W-1:0] n_samples;
  logic             pulse_armed;
  longint           pulse_enc;
  longint           offset_val;
  logic             calibrated;
  logic             mismatched;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void clear_calibration();
    diff_total  = 0;
    n_samples   = '0;
    pulse_armed = 1'b0;
    pulse_enc   = 0;
    offset_val  = 0;
    calibrated  = 1'b0;
    mismatched  = 1'b0;
  endfunction

  // Applies one accepted request to the model and returns its result.
  // Section = ceil((2n*idx + 2*sum - n*U) / (2*n*U)), done as two floor
  // divides plus a ceiling on the leftover fraction, all exact.
  function automatic cal_result_t advance_calibration(input sample_t s);
    cal_result_t r;
    longint enc_v, pot_v, u, n, q, rem, a, k, m, num, den, off, pos;
    enc_v = longint'(signed'(s.encoder_count));
    pot_v = longint'(signed'(s.pot_reading));
    if (s.func == FUNC_CLEAR) begin
      clear_calibration();
    end else begin
      // accumulation freezes once the count saturates
      if (n_samples != CNT_MAX) begin
        diff_total += pot_v - enc_v;
        n_samples++;
      end
      if (s.index_seen) begin
        pulse_armed = 1'b1;
        pulse_enc   = enc_v;
      end
      if (pulse_armed && n_samples >= m_mins && n_samples != '0) begin
        u = (m_cpi == '0) ? 1 : longint'(m_cpi);
        n = longint'(n_samples);
        q = diff_total / n;
        rem = diff_total % n;
        if (rem < 0) begin
          q--;
          rem += n;
        end
        a = 2 * (pulse_enc + q) - u;
        k = a / (2 * u);
        m = a % (2 * u);
        if (m < 0) begin
          k--;
          m += 2 * u;
        end
        num = m * n + 2 * rem;
        den = 2 * n * u;
        k += (num + den - 1) / den;
        off = k * u - pulse_enc;
        if (!calibrated) begin
          offset_val = off;
          calibrated = 1'b1;
        end else if (offset_val != off) begin
          mismatched = 1'b1;
        end
        pulse_armed = 1'b0;
      end
    end
    pos = enc_v + offset_val;
    if (pos > POS_HI) pos = POS_HI;
    if (pos < POS_LO) pos = POS_LO;
    r.position        = POS_W'(pos);
    r.offset_valid    = calibrated;
    r.offset_mismatch = mismatched;
    return r;
  endfunction

  // Driver: next request goes out once the current one is taken
  always @(posedge clk) begin : drive_requests
    sample_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (sample_fifo.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = sample_fifo.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.func          <= nxt.func;
        in_ch.encoder_count <= nxt.encoder_count;
        in_ch.pot_reading   <= nxt.pot_reading;
        in_ch.index_seen    <= nxt.index_seen;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: register writes and accepted requests feed the model,
  // accepted results are checked against the oldest prediction
  always @(posedge clk) begin : monitor
    sample_t     req;
    cal_result_t want;
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_COUNTS_PER_INDEX: m_cpi  = cfg_ch.data;
        CFG_MIN_SAMPLES:      m_mins = cfg_ch.data;
        default: ;
      endcase
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      req.func          = in_ch.func;
      req.encoder_count = in_ch.encoder_count;
      req.pot_reading   = in_ch.pot_reading;
      req.index_seen    = in_ch.index_seen;
      expected_q.push_back(advance_calibration(req));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: position %0d calibrated %0b mismatch %0b",
                 $time, out_ch.position, out_ch.offset_valid, out_ch.offset_mismatch);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.position !== want.position) begin
          errors++;
          $display("%0t position: expected %0d, got %0d", $time,
                   $signed(want.position), out_ch.position);
        end
        if (out_ch.offset_valid !== want.offset_valid) begin
          errors++;
          $display("%0t offset_valid: expected %0b, got %0b", $time,
                   want.offset_valid, out_ch.offset_valid);
        end
        if (out_ch.offset_mismatch !== want.offset_mismatch) begin
          errors++;
          $display("%0t offset_mismatch: expected %0b, got %0b", $time,
                   want.offset_mismatch, out_ch.offset_mismatch);
        end
      end
    end
  end

  function automatic sample_t mk(input logic f, input longint e, input longint p,
                                 input logic idx);
    sample_t s;
    s.func          = f;
    s.encoder_count = IN_W'(e);
    s.pot_reading   = IN_W'(p);
    s.index_seen    = idx;
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] cpi, input logic [CFG_W-1:0] mins);
    write_reg(CFG_COUNTS_PER_INDEX, cpi);
    write_reg(CFG_MIN_SAMPLES, mins);
    gen_cpi  = cpi;
    gen_mins = mins;
  endtask

  // Block until every queued request is taken and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (sample_fifo.size() != 0 || in_ch.valid || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One calibration run: clear, then samples with pot = encoder + base + noise.
  // Base is chosen so the pot-derived index sits mid-section, so aligned
  // pulses all agree on the offset; a few pulses are deliberately off-grid.
  task automatic push_run(input int len);
    longint u, idx0, cmax, base, nz, e;
    int     k;
    logic   pulse;
    u    = (gen_cpi == '0) ? 1 : longint'(gen_cpi);
    idx0 = longint'($urandom_range(1 << 29)) - (longint'(1) << 28);
    cmax = (longint'(1) << 29) / u;
    base = (longint'($urandom_range(int'(2 * cmax))) - cmax) * u - idx0;
    nz   = u / 4;
    sample_fifo.push_back(mk(FUNC_CLEAR, $urandom(), $urandom(), 1'($urandom_range(1))));
    for (int j = 0; j < len; j++) begin
      pulse = ($urandom_range(7) == 0);
      k     = $urandom_range(6) - 3;
      e     = idx0 + k * u;
      if (!pulse || $urandom_range(15) == 0) begin
        e += longint'($urandom_range(int'(2 * u))) - u;
      end
      sample_fifo.push_back(mk(FUNC_SAMPLE, e,
                               e + base + longint'($urandom_range(int'(2 * nz))) - nz,
                               pulse));
    end
  endtask

  // Mostly calibration runs, some bursts of fully random requests
  task automatic run_phase(input int n_items);
    int cnt, len;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(4) != 0) begin
        len = $urandom_range(3, 30) + ((gen_mins <= 100) ? int'(gen_mins) : 0);
        push_run(len);
        cnt += len + 1;
      end else begin
        len = $urandom_range(1, 10);
        repeat (len) begin
          sample_fifo.push_back(mk(($urandom_range(7) == 0) ? FUNC_CLEAR : FUNC_SAMPLE,
                                   $urandom(), $urandom(), 1'($urandom_range(1))));
        end
        cnt += len;
      end
    end
    wait_drained();
  endtask

  initial begin
    logic [CFG_W-1:0] cpi_pick;
    errors          = 0;
    cycle_cnt       = 0;
    send_gap_pct    = 9;
    recv_stall_pct  = 66;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_SAMPLE;
    in_ch.encoder_count = '0;
    in_ch.pot_reading   = '0;
    in_ch.index_seen    = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_COUNTS_PER_INDEX;
    cfg_ch.data     = '0;
    m_cpi           = CPI_RESET;
    m_mins          = MINS_RESET;
    gen_cpi         = CPI_RESET;
    gen_mins        = MINS_RESET;
    clear_calibration();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: clears at the input extremes, extreme differences,
    // a pulse that stays pending because too few samples are in
    sample_fifo.push_back(mk(FUNC_CLEAR, S32_MAX, 0, 1'b1));
    sample_fifo.push_back(mk(FUNC_CLEAR, S32_MIN, -1, 1'b0));
    sample_fifo.push_back(mk(FUNC_SAMPLE, S32_MAX, S32_MIN, 1'b0));
    sample_fifo.push_back(mk(FUNC_SAMPLE, S32_MIN, S32_MAX, 1'b1));
    sample_fifo.push_back(mk(FUNC_SAMPLE, 0, -1, 1'b0));
    wait_drained();

    // One count per period, calibrate at once: agree, then disagree,
    // then offsets that push the position into both saturation limits
    set_config(CFG_W'(1), CFG_W'(1));
    sample_fifo.push_back(mk(FUNC_SAMPLE, 100, 100, 1'b1));
    sample_fifo.push_back(mk(FUNC_SAMPLE, 100, 200, 1'b1));
    sample_fifo.push_back(mk(FUNC_SAMPLE, 5, 5, 1'b0));
    sample_fifo.push_back(mk(FUNC_CLEAR, 7, 0, 1'b0));
    sample_fifo.push_back(mk(FUNC_SAMPLE, 0, S32_MAX, 1'b1));
    sample_fifo.push_back(mk(FUNC_SAMPLE, S32_MAX, S32_MAX, 1'b0));
    sample_fifo.push_back(mk(FUNC_CLEAR, S32_MIN, 0, 1'b0));
    sample_fifo.push_back(mk(FUNC_SAMPLE, 0, S32_MIN, 1'b1));
    sample_fifo.push_back(mk(FUNC_SAMPLE, S32_MIN, 0, 1'b0));
    sample_fifo.push_back(mk(FUNC_SAMPLE, S32_MAX, S32_MIN, 1'b1));
    wait_drained();

    // Zero period length acts as one; zero sample minimum calibrates on
    // the first pending pulse
    set_config('0, '0);
    sample_fifo.push_back(mk(FUNC_CLEAR, 0, 0, 1'b0));
    sample_fifo.push_back(mk(FUNC_SAMPLE, 3, 10, 1'b1));
    sample_fifo.push_back(mk(FUNC_SAMPLE, -9, -2, 1'b0));
    sample_fifo.push_back(mk(FUNC_SAMPLE, 4, 11, 1'b1));
    wait_drained();

    // Largest settings: the sample minimum is never reached
    set_config({CFG_W{1'b1}}, {CFG_W{1'b1}});
    sample_fifo.push_back(mk(FUNC_SAMPLE, 12345, -6789, 1'b1));
    run_phase(100);

    // Back to reset values, random runs long enough to calibrate
    set_config(CPI_RESET, MINS_RESET);
    run_phase(250);

    // Random settings; sender-light/receiver-heavy idling, then swapped,
    // then none at all
    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          send_gap_pct   = 9;
          recv_stall_pct = 66;
        end
        1: begin
          send_gap_pct   = 66;
          recv_stall_pct = 9;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      case ($urandom_range(3))
        0:       cpi_pick = CFG_W'($urandom_range(1, 16));
        1:       cpi_pick = CFG_W'(1) << $urandom_range(CFG_W - 1);
        2:       cpi_pick = CFG_W'($urandom_range(1, (1 << CFG_W) - 1));
        default: cpi_pick = CFG_W'($urandom_range(17, 5000));
      endcase
      set_config(cpi_pick, CFG_W'($urandom_range(1, 40)));
      run_phase(230);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
